// ===== rtl/mpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix parity check and correct: shared package
// Verdict codes, beat field widths and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mpcc_pkg;

    // Verdict codes carried in the result beat.
    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_CHANGE  = 2'd1;
    localparam logic [1:0] VERDICT_CORRUPT = 2'd2;

    // Fixed field widths.
    localparam int CFG_W   = 8;
    localparam int FAULT_W = 8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;   // write zero at the sweep address and step it
        logic load;       // input channel is open
        logic scan_rd;    // read and zero the column store at the sweep address and step it
        logic eval;       // form the verdict and load the output register
    } mpcc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done; // sweep address is at the last entry of the store
        logic scan_done;  // sweep address is at the last column of the matrix
        logic mat_end;    // the last bit of a matrix is taken in this cycle
        logic out_free;   // the output register can take a new result
    } mpcc_status_t;

endpackage

`default_nettype wire

// ===== rtl/mpcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Matrix parity check and correct: controller
// Sequences the store clearing sweep, bit loading, the column parity scan
// and the verdict hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpcc_ctrl
    import mpcc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire mpcc_status_t status,
    output mpcc_cmd_t         cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;
    localparam logic [2:0] ST_EVAL  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next-state logic; a register write always restarts with a clearing sweep.
    always_comb begin
        state_next = state_reg;
        if (cfg_wr_en) begin
            state_next = ST_CLEAR;
        end else begin
            unique case (state_reg)
                ST_CLEAR: if (status.clear_done) state_next = ST_LOAD;
                ST_LOAD:  if (status.mat_end) state_next = ST_DRAIN;
                ST_DRAIN: state_next = ST_SCAN;
                ST_SCAN:  if (status.scan_done) state_next = ST_FINAL;
                ST_FINAL: state_next = ST_EVAL;
                ST_EVAL:  if (status.out_free) state_next = ST_LOAD;
                default:  state_next = ST_CLEAR;
            endcase
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command decode.
    always_comb begin
        cmd.clear_wr = (state_reg == ST_CLEAR);
        cmd.load     = (state_reg == ST_LOAD);
        cmd.scan_rd  = (state_reg == ST_SCAN);
        cmd.eval     = (state_reg == ST_EVAL) && status.out_free;
    end

    // A matrix end is only ever reported while loading.
    a_mat_end_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        status.mat_end |-> cmd.load)
        else $error("matrix end outside the load phase");

    // After a matrix end the next cycle drains the last store write.
    a_drain_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.mat_end && !cfg_wr_en) |=> (state_reg == ST_DRAIN))
        else $error("no drain cycle after matrix end");

    // A finished scan is followed by the final data cycle, then evaluation.
    a_final_then_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL && !cfg_wr_en) |=> (state_reg == ST_EVAL))
        else $error("evaluation does not follow the final scan cycle");

endmodule

`default_nettype wire

// ===== rtl/mpcc_datapath.sv =====
// ----------------------------------------------------------------------------
// Matrix parity check and correct: datapath
// Column parity store with a read-modify-write stage, row parity and odd-row
// tracking, the column scan accumulator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpcc_datapath
    import mpcc_pkg::*;
#(
    parameter int MAX_SIZE = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_W-1:0]   cfg_wr_data,
    input  wire mpcc_cmd_t          cmd,
    output mpcc_status_t            status,
    input  wire logic               s_valid,
    input  wire logic               s_bit,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic [1:0]              m_verdict,
    output logic [FAULT_W-1:0]      m_fault_row,
    output logic [FAULT_W-1:0]      m_fault_col
);

    localparam int IW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CW       = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
    localparam int RST_SIZE = (MAX_SIZE < 4) ? MAX_SIZE : 4;

    // Column parity store, one bit per column.
    logic          col_mem [MAX_SIZE];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic          rdata_reg;

    // Matrix geometry and positions.
    logic [IW-1:0] size_last_reg, size_last_next;
    logic [IW-1:0] col_pos_reg, col_pos_next;
    logic [IW-1:0] row_pos_reg, row_pos_next;
    logic [IW-1:0] cnt_reg, cnt_next;

    // Row tracking.
    logic          row_par_reg, row_par_next;
    logic [1:0]    odd_rows_reg, odd_rows_next;
    logic [IW-1:0] first_row_reg, first_row_next;

    // Read-modify-write stage for one loaded bit.
    logic          s2_valid_reg, s2_valid_next;
    logic [IW-1:0] s2_addr_reg;
    logic          s2_bit_reg;
    logic          s2_fwd_reg;
    logic          wlast_reg;
    logic          s2_new;

    // Scan read pipeline and column accumulation.
    logic          sc_valid_reg, sc_valid_next;
    logic [IW-1:0] sc_addr_reg;
    logic [1:0]    odd_cols_reg, odd_cols_next;
    logic [IW-1:0] first_col_reg, first_col_next;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_verdict_reg;
    logic [FAULT_W-1:0] out_row_reg;
    logic [FAULT_W-1:0] out_col_reg;
    logic [1:0]         verdict;
    logic [IW:0]        row_one;
    logic [IW:0]        col_one;

    logic          accept;
    logic          col_last;
    logic          row_last;
    logic          row_par_new;
    logic [CW-1:0] cfg_ext;

    assign accept      = cmd.load && s_valid;
    assign col_last    = (col_pos_reg == size_last_reg);
    assign row_last    = (row_pos_reg == size_last_reg);
    assign row_par_new = row_par_reg ^ s_bit;
    assign cfg_ext     = CW'(cfg_wr_data);

    // Status toward the controller.
    always_comb begin
        status.clear_done = (cnt_reg == IW'(MAX_SIZE - 1));
        status.scan_done  = (cnt_reg == size_last_reg);
        status.mat_end    = accept && col_last && row_last;
        status.out_free   = !out_valid_reg || m_ready;
    end

    // New parity of the column held in the write stage, forwarded when the
    // previous write hit the same column.
    assign s2_new = (s2_fwd_reg ? wlast_reg : rdata_reg) ^ s2_bit_reg;

    // Store port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = 1'b0;
        if (cmd.clear_wr || cmd.scan_rd) begin
            mem_we = 1'b1;
        end else if (s2_valid_reg) begin
            mem_we    = 1'b1;
            mem_waddr = s2_addr_reg;
            mem_wdata = s2_new;
        end
        mem_raddr = cmd.scan_rd ? cnt_reg : col_pos_reg;
    end

    // Column parity store.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            col_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= col_mem[mem_raddr];
    end

    // Size register, clamped to the supported range on write.
    always_comb begin
        size_last_next = size_last_reg;
        if (cfg_wr_en) begin
            priority if (cfg_ext == '0) begin
                size_last_next = '0;
            end else if (cfg_ext > CW'(MAX_SIZE)) begin
                size_last_next = IW'(MAX_SIZE - 1);
            end else begin
                size_last_next = IW'(cfg_ext - CW'(1));
            end
        end
    end

    // Sweep counter shared by the clearing pass and the scan.
    always_comb begin
        cnt_next = cnt_reg;
        if (cfg_wr_en) begin
            cnt_next = '0;
        end else if (cmd.clear_wr) begin
            cnt_next = status.clear_done ? '0 : cnt_reg + IW'(1);
        end else if (cmd.scan_rd) begin
            cnt_next = status.scan_done ? '0 : cnt_reg + IW'(1);
        end
    end

    // Positions and row parity tracking.
    always_comb begin
        col_pos_next   = col_pos_reg;
        row_pos_next   = row_pos_reg;
        row_par_next   = row_par_reg;
        odd_rows_next  = odd_rows_reg;
        first_row_next = first_row_reg;
        if (cfg_wr_en) begin
            col_pos_next  = '0;
            row_pos_next  = '0;
            row_par_next  = 1'b0;
            odd_rows_next = '0;
        end else if (cmd.eval) begin
            odd_rows_next = '0;
        end else if (accept) begin
            if (col_last) begin
                col_pos_next = '0;
                row_par_next = 1'b0;
                row_pos_next = row_last ? '0 : row_pos_reg + IW'(1);
                if (row_par_new) begin
                    if (odd_rows_reg == 2'd0) begin
                        first_row_next = row_pos_reg;
                    end
                    if (odd_rows_reg != 2'd2) begin
                        odd_rows_next = odd_rows_reg + 2'd1;
                    end
                end
            end else begin
                col_pos_next = col_pos_reg + IW'(1);
                row_par_next = row_par_new;
            end
        end
    end

    // Column scan accumulation; read data arrives in the cycle after each read.
    always_comb begin
        sc_valid_next  = cmd.scan_rd && !cfg_wr_en;
        odd_cols_next  = odd_cols_reg;
        first_col_next = first_col_reg;
        if (cfg_wr_en || cmd.eval) begin
            odd_cols_next = '0;
        end else if (sc_valid_reg && rdata_reg) begin
            if (odd_cols_reg == 2'd0) begin
                first_col_next = sc_addr_reg;
            end
            if (odd_cols_reg != 2'd2) begin
                odd_cols_next = odd_cols_reg + 2'd1;
            end
        end
    end

    // Write stage valid: a bit taken now is written back next cycle.
    assign s2_valid_next = accept && !cfg_wr_en;

    // Verdict from the row and column tallies.
    assign row_one = {1'b0, first_row_reg} + (IW + 1)'(1);
    assign col_one = {1'b0, first_col_reg} + (IW + 1)'(1);
    always_comb begin
        priority if (odd_rows_reg == 2'd0 && odd_cols_reg == 2'd0) begin
            verdict = VERDICT_OK;
        end else if (odd_rows_reg == 2'd1 && odd_cols_reg == 2'd1) begin
            verdict = VERDICT_CHANGE;
        end else begin
            verdict = VERDICT_CORRUPT;
        end
    end

    // Output register valid: set on evaluation, cleared when the beat is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.eval) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_last_reg <= IW'(RST_SIZE - 1);
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            cnt_reg       <= '0;
            row_par_reg   <= 1'b0;
            odd_rows_reg  <= '0;
            odd_cols_reg  <= '0;
            s2_valid_reg  <= 1'b0;
            sc_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            size_last_reg <= size_last_next;
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            cnt_reg       <= cnt_next;
            row_par_reg   <= row_par_next;
            odd_rows_reg  <= odd_rows_next;
            odd_cols_reg  <= odd_cols_next;
            s2_valid_reg  <= s2_valid_next;
            sc_valid_reg  <= sc_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        first_row_reg <= first_row_next;
        first_col_reg <= first_col_next;
        s2_addr_reg   <= col_pos_reg;
        s2_bit_reg    <= s_bit;
        s2_fwd_reg    <= s2_valid_reg && (s2_addr_reg == col_pos_reg);
        wlast_reg     <= mem_wdata;
        sc_addr_reg   <= cnt_reg;
        if (cmd.eval) begin
            out_verdict_reg <= verdict;
            out_row_reg     <= (verdict == VERDICT_CHANGE) ? FAULT_W'(row_one) : '0;
            out_col_reg     <= (verdict == VERDICT_CHANGE) ? FAULT_W'(col_one) : '0;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_verdict   = out_verdict_reg;
    assign m_fault_row = out_row_reg;
    assign m_fault_col = out_col_reg;

    // The clearing sweep never overlaps a pending load write.
    a_clear_no_load_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_wr |-> !s2_valid_reg)
        else $error("load write pending during the clearing sweep");

    // The scan starts only after the last load write has landed.
    a_scan_no_load_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_rd |-> !s2_valid_reg)
        else $error("load write pending during the column scan");

    // Evaluation sees every scanned column.
    a_eval_scan_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval |-> !sc_valid_reg)
        else $error("evaluation before the last column read returned");

    // Positions stay inside the configured matrix.
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (row_pos_reg <= size_last_reg) && (col_pos_reg <= size_last_reg))
        else $error("position beyond the configured size");

endmodule

`default_nettype wire

// ===== rtl/matrix_parity_check_correct_unit.sv =====
// ----------------------------------------------------------------------------
// Matrix parity check and correct unit
// Two-dimensional parity check over a square bit matrix taken in row-major
// order, with location of a single flipped bit.
// ----------------------------------------------------------------------------
// Loading takes one bit per cycle during the load phase; the input is held
// off otherwise. The column parity store is updated by a read-modify-write
// stage behind the input. After the last bit of a matrix the controller
// drains the last store write, scans the store's read port over size columns,
// takes the last read and forms the verdict, then offers the result beat
// once the output register is free.
// After reset and after every write of matrix_size, a clearing sweep over
// all MAX_SIZE store entries zeroes the store while the input is held off.
`default_nettype none

module matrix_parity_check_correct_unit
    import mpcc_pkg::*;
#(
    parameter int MAX_SIZE = 128
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // Configuration: matrix_size.
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    // Input beats.
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [0] bit_value, [7:1] zero
    // Result beats.
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [23:0]           m_tdata    // [1:0] verdict, [9:2] fault_row,
                                             // [17:10] fault_col, [23:18] zero
);

    mpcc_cmd_t          cmd;
    mpcc_status_t       status;
    logic [1:0]         verdict;
    logic [FAULT_W-1:0] fault_row;
    logic [FAULT_W-1:0] fault_col;

    // Sequencer.
    mpcc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .status    (status),
        .cmd       (cmd)
    );

    // Parity store, tallies and result register.
    mpcc_datapath #(
        .MAX_SIZE (MAX_SIZE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .s_valid     (s_tvalid),
        .s_bit       (s_tdata[0]),
        .m_ready     (m_tready),
        .m_valid     (m_tvalid),
        .m_verdict   (verdict),
        .m_fault_row (fault_row),
        .m_fault_col (fault_col)
    );

    assign s_tready = cmd.load;
    assign m_tdata  = {6'd0, fault_col, fault_row, verdict};

endmodule

`default_nettype wire
